// ===== design/dpds_pkg.sv =====
// Shared types, constants and tables of the DSI PLL divider search.
// Used by every other file of the project; depends on nothing.
package dpds_pkg;

    // Field widths.
    localparam int W_PCLK   = 20;
    localparam int W_LINK   = 25;
    localparam int W_CALC   = 21;
    localparam int W_M      = 7;
    localparam int W_P      = 3;
    localparam int W_ONEHOT = 5;
    localparam int W_NFIELD = 2;
    localparam int W_SEED   = 9;
    localparam int W_LANES  = 3;
    localparam int W_FMT    = 2;
    localparam int W_CFG    = 3;
    localparam int W_CFGIDX = 2;
    localparam int W_BPP    = 5;

    // Configuration register indexes.
    localparam logic [W_CFGIDX-1:0] REG_PLATFORM     = 2'd0;
    localparam logic [W_CFGIDX-1:0] REG_PIXEL_FORMAT = 2'd1;
    localparam logic [W_CFGIDX-1:0] REG_LANE_COUNT   = 2'd2;

    // Pixel format codes that change the bit count.
    localparam logic [W_FMT-1:0] FMT_RGB666_PACKED = 2'd2;
    localparam logic [W_FMT-1:0] FMT_RGB565        = 2'd3;

    localparam logic [W_BPP-1:0] BPP_24 = 5'd24;
    localparam logic [W_BPP-1:0] BPP_18 = 5'd18;
    localparam logic [W_BPP-1:0] BPP_16 = 5'd16;

    localparam logic [W_LANES-1:0] LANES_RESET = 3'd4;

    // Link clock window in kHz.
    localparam logic [W_LINK-1:0] LINK_MIN_KHZ = 25'd300000;
    localparam logic [W_LINK-1:0] LINK_MAX_KHZ = 25'd1150000;

    // Reference over n is 25000 kHz on both platforms (25000/1 and 100000/4).
    localparam int REF_PER_N = 25000;

    localparam logic [W_M-1:0] M_LO_PLAT0 = 7'd62;
    localparam logic [W_M-1:0] M_HI_PLAT0 = 7'd92;
    localparam logic [W_M-1:0] M_LO_PLAT1 = 7'd70;
    localparam logic [W_M-1:0] M_HI_PLAT1 = 7'd96;

    localparam logic [W_NFIELD-1:0] NFIELD_PLAT0 = 2'd0;
    localparam logic [W_NFIELD-1:0] NFIELD_PLAT1 = 2'd2;

    // Post divider range, one search cell for each value.
    localparam int P_MIN = 2;
    localparam int NCELL = 5;

    // LFSR seeds of m, starting at m = 62.
    localparam logic [W_M-1:0] SEED_BASE  = 7'd62;
    localparam int             SEED_DEPTH = 39;
    localparam int             W_SEEDIDX  = $clog2(SEED_DEPTH);
    localparam logic [W_SEED-1:0] SEED_TABLE [0:SEED_DEPTH-1] = '{
        9'd426, 9'd469, 9'd234, 9'd373, 9'd442, 9'd221, 9'd110, 9'd311, 9'd411,
        9'd461, 9'd486, 9'd243, 9'd377, 9'd188, 9'd350, 9'd175, 9'd343, 9'd427,
        9'd213, 9'd106, 9'd53,  9'd282, 9'd397, 9'd454, 9'd227, 9'd113, 9'd56,
        9'd284, 9'd142, 9'd71,  9'd35,  9'd273, 9'd136, 9'd324, 9'd418, 9'd465,
        9'd488, 9'd500, 9'd506
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_LOAD,
        S_SEARCH,
        S_REDUCE,
        S_DONE
    } t_state;

    // Control shared by all search cells.
    typedef struct packed {
        logic load;
        logic plat;
        logic run;
    } t_cell_ctl;

    // Best candidate travelling along the cell row.
    typedef struct packed {
        logic [W_CALC-1:0] err;
        logic [W_M-1:0]    m;
        logic [W_P-1:0]    p;
    } t_token;

    function automatic logic [W_BPP-1:0] bits_per_pixel(input logic [W_FMT-1:0] fmt);
        logic [W_BPP-1:0] bpp;
        priority if (fmt == FMT_RGB666_PACKED) begin
            bpp = BPP_18;
        end else if (fmt == FMT_RGB565) begin
            bpp = BPP_16;
        end else begin
            bpp = BPP_24;
        end
        return bpp;
    endfunction

endpackage

// ===== design/dpds_div.sv =====
// Bit-serial restoring divider for the link clock: one quotient bit per cycle.
// Depends on dpds_pkg.
module dpds_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dpds_pkg::W_LINK-1:0]   i_dividend,
    input  logic [dpds_pkg::W_LANES-1:0]  i_divisor,
    output logic                          o_done,
    output logic [dpds_pkg::W_LINK-1:0]   o_quotient
);

    localparam int W_CNT = $clog2(dpds_pkg::W_LINK);
    localparam logic [W_CNT-1:0] CNT_LAST = W_CNT'(dpds_pkg::W_LINK - 1);

    logic                         r_busy;
    logic                         r_done;
    logic [W_CNT-1:0]             r_cnt;
    logic [dpds_pkg::W_LINK-1:0]  r_quo;
    logic [dpds_pkg::W_LANES-1:0] r_rem;
    logic [dpds_pkg::W_LANES-1:0] r_den;

    logic [dpds_pkg::W_LANES:0]   w_trial;
    logic                         w_fit;
    logic [dpds_pkg::W_LANES-1:0] w_rem;

    // The remainder stays below the divisor, so the trial value fits one extra bit.
    always_comb begin
        w_trial = {r_rem, r_quo[dpds_pkg::W_LINK-1]};
        w_fit   = (w_trial >= {1'b0, r_den});
        if (w_fit) begin
            w_rem = dpds_pkg::W_LANES'(w_trial - {1'b0, r_den});
        end else begin
            w_rem = w_trial[dpds_pkg::W_LANES-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + W_CNT'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[dpds_pkg::W_LINK-2:0], w_fit};
            r_rem <= w_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== design/dpds_cell.sv =====
// One search cell: tracks floor(m * 25000 / P) for its own post divider P,
// keeps its best m, and merges its best into the token passed down the row.
// Depends on dpds_pkg.
module dpds_cell #(
    parameter int P = dpds_pkg::P_MIN
) (
    input  logic                         i_clk,
    input  dpds_pkg::t_cell_ctl          i_ctl,
    input  logic [dpds_pkg::W_CALC-1:0]  i_link,
    input  logic [dpds_pkg::W_M-1:0]     i_m,
    input  dpds_pkg::t_token             i_tok,
    output dpds_pkg::t_token             o_tok
);

    localparam int W_REM  = $clog2(P) + 1;
    localparam int STEP_Q = dpds_pkg::REF_PER_N / P;
    localparam int STEP_R = dpds_pkg::REF_PER_N % P;
    localparam int PROD0  = int'(dpds_pkg::M_LO_PLAT0) * dpds_pkg::REF_PER_N;
    localparam int PROD1  = int'(dpds_pkg::M_LO_PLAT1) * dpds_pkg::REF_PER_N;
    localparam int INIT_Q0 = PROD0 / P;
    localparam int INIT_R0 = PROD0 % P;
    localparam int INIT_Q1 = PROD1 / P;
    localparam int INIT_R1 = PROD1 % P;

    logic [dpds_pkg::W_CALC-1:0] r_q;
    logic [W_REM-1:0]            r_r;
    logic [dpds_pkg::W_CALC-1:0] r_best_err;
    logic [dpds_pkg::W_M-1:0]    r_best_m;
    dpds_pkg::t_token            r_tok;

    logic [W_REM-1:0]            w_rsum;
    logic                        w_wrap;
    logic [dpds_pkg::W_CALC-1:0] w_err;
    logic                        w_better;
    logic                        w_win;

    always_comb begin
        w_rsum = r_r + W_REM'(STEP_R);
        w_wrap = (w_rsum >= W_REM'(P));
        if (r_q > i_link) begin
            w_err = r_q - i_link;
        end else begin
            w_err = i_link - r_q;
        end
        w_better = (w_err < r_best_err);
        // Strict order on (error, m) keeps the first minimum in m-major order.
        w_win = (r_best_err < i_tok.err) ||
                ((r_best_err == i_tok.err) && (r_best_m < i_tok.m));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_q        <= i_ctl.plat ? dpds_pkg::W_CALC'(INIT_Q1) : dpds_pkg::W_CALC'(INIT_Q0);
            r_r        <= i_ctl.plat ? W_REM'(INIT_R1) : W_REM'(INIT_R0);
            r_best_err <= '1;
            r_best_m   <= i_m;
        end else if (i_ctl.run) begin
            r_q <= r_q + dpds_pkg::W_CALC'(STEP_Q) + dpds_pkg::W_CALC'(w_wrap);
            r_r <= w_wrap ? (w_rsum - W_REM'(P)) : w_rsum;
            if (w_better) begin
                r_best_err <= w_err;
                r_best_m   <= i_m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_win) begin
            r_tok.err <= r_best_err;
            r_tok.m   <= r_best_m;
            r_tok.p   <= dpds_pkg::W_P'(P);
        end else begin
            r_tok <= i_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== design/dsi_pll_divider_search.sv =====
// Top level of the DSI PLL divider search: configuration, sequencer, divider
// and the row of search cells. Depends on dpds_pkg, dpds_div and dpds_cell.

// Each item is a pixel clock in kHz and gives exactly one result. The link
// clock is pixel clock times bits per pixel over the lane count, rounded to
// nearest; a lane count of zero counts as one. A link clock outside 300000 to
// 1150000 kHz returns status 1 with all divider fields zero once the
// bit-serial divider (one quotient bit per cycle, 25 bits) has finished.
// Otherwise the search sweeps m over its platform range one value per cycle
// (31 values on platform 0, 27 on platform 1) while five cells, one per post
// divider 2 to 6, each compare their candidate against the link clock at
// once. A token then ripples through the five cells to pick the first minimum
// in m-major order. One item is worked on at a time; a new item is taken as
// soon as the previous result sits in the output register, even if the
// downstream side is still stalling it. Configuration writes are meant for
// idle periods only and take effect at once.
module dsi_pll_divider_search (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [dpds_pkg::W_CFGIDX-1:0]   i_cfg_index,
    input  logic [dpds_pkg::W_CFG-1:0]      i_cfg_data,
    // input items
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [dpds_pkg::W_PCLK-1:0]     i_pixel_clock_khz,
    // result items
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_status,
    output logic [dpds_pkg::W_LINK-1:0]     o_link_clock_khz,
    output logic [dpds_pkg::W_M-1:0]        o_m_divider,
    output logic [dpds_pkg::W_P-1:0]        o_p_divider,
    output logic [dpds_pkg::W_ONEHOT-1:0]   o_post_div_onehot,
    output logic [dpds_pkg::W_NFIELD-1:0]   o_n_field,
    output logic [dpds_pkg::W_SEED-1:0]     o_m_seed
);

    localparam int W_CNT = $clog2(dpds_pkg::NCELL + 1);
    localparam logic [W_CNT-1:0] CNT_REDUCE = W_CNT'(dpds_pkg::NCELL);

    // Configuration registers.
    logic                          r_platform;
    logic [dpds_pkg::W_FMT-1:0]    r_pixel_format;
    logic [dpds_pkg::W_LANES-1:0]  r_lane_count;

    // Sequencer.
    dpds_pkg::t_state              r_state;
    dpds_pkg::t_state              n_state;
    logic [dpds_pkg::W_M-1:0]      r_m;
    logic [W_CNT-1:0]              r_cnt;

    // Result of the current item.
    logic [dpds_pkg::W_LINK-1:0]   r_link;
    logic                          r_status;
    logic [dpds_pkg::W_M-1:0]      r_res_m;
    logic [dpds_pkg::W_P-1:0]      r_res_p;

    // Output register.
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic                          r_out_status;
    logic [dpds_pkg::W_LINK-1:0]   r_out_link;
    logic [dpds_pkg::W_M-1:0]      r_out_m;
    logic [dpds_pkg::W_P-1:0]      r_out_p;
    logic [dpds_pkg::W_ONEHOT-1:0] r_out_onehot;
    logic [dpds_pkg::W_NFIELD-1:0] r_out_nfield;
    logic [dpds_pkg::W_SEED-1:0]   r_out_seed;

    logic                          w_accept;
    logic                          w_div_start;
    logic                          w_div_done;
    logic [dpds_pkg::W_LINK-1:0]   w_quo;
    logic [dpds_pkg::W_LINK-1:0]   w_dividend;
    logic [dpds_pkg::W_LANES-1:0]  w_lanes;
    logic                          w_oor;
    logic                          w_out_load;
    logic [dpds_pkg::W_M-1:0]      w_m_lo;
    logic [dpds_pkg::W_M-1:0]      w_m_hi;
    dpds_pkg::t_cell_ctl           w_ctl;
    dpds_pkg::t_token              w_tok [0:dpds_pkg::NCELL];
    logic [dpds_pkg::W_M-1:0]      w_seed_off;
    logic [dpds_pkg::W_ONEHOT-1:0] w_onehot;

    // Configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_platform     <= 1'b0;
            r_pixel_format <= '0;
            r_lane_count   <= dpds_pkg::LANES_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dpds_pkg::REG_PLATFORM:     r_platform     <= i_cfg_data[0];
                dpds_pkg::REG_PIXEL_FORMAT: r_pixel_format <= i_cfg_data[dpds_pkg::W_FMT-1:0];
                dpds_pkg::REG_LANE_COUNT:   r_lane_count   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Link clock numerator: bits per pixel is a constant of the format, and
    // half the lane count is added so the divider rounds to nearest.
    always_comb begin
        w_lanes    = (r_lane_count == '0) ? dpds_pkg::W_LANES'(1) : r_lane_count;
        w_dividend = dpds_pkg::W_LINK'(i_pixel_clock_khz)
                   * dpds_pkg::W_LINK'(dpds_pkg::bits_per_pixel(r_pixel_format))
                   + dpds_pkg::W_LINK'(w_lanes >> 1);
        w_m_lo     = r_platform ? dpds_pkg::M_LO_PLAT1 : dpds_pkg::M_LO_PLAT0;
        w_m_hi     = r_platform ? dpds_pkg::M_HI_PLAT1 : dpds_pkg::M_HI_PLAT0;
        w_oor      = (w_quo < dpds_pkg::LINK_MIN_KHZ) || (w_quo > dpds_pkg::LINK_MAX_KHZ);
    end

    dpds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_lanes),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // The first cell sees a token that any real candidate beats.
    assign w_tok[0] = '{err: '1, m: '1, p: dpds_pkg::W_P'(dpds_pkg::P_MIN)};

    for (genvar k = 0; k < dpds_pkg::NCELL; k++) begin : g_cell
        dpds_cell #(
            .P (dpds_pkg::P_MIN + k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_link (r_link[dpds_pkg::W_CALC-1:0]),
            .i_m    (r_m),
            .i_tok  (w_tok[k]),
            .o_tok  (w_tok[k+1])
        );
    end

    // Next state and control.
    always_comb begin
        n_state     = r_state;
        w_accept    = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        w_ctl       = '{load: 1'b0, plat: r_platform, run: 1'b0};
        unique case (r_state)
            dpds_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    w_accept    = 1'b1;
                    w_div_start = 1'b1;
                    n_state     = dpds_pkg::S_DIV;
                end
            end
            dpds_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = w_oor ? dpds_pkg::S_DONE : dpds_pkg::S_LOAD;
                end
            end
            dpds_pkg::S_LOAD: begin
                w_ctl.load = 1'b1;
                n_state    = dpds_pkg::S_SEARCH;
            end
            dpds_pkg::S_SEARCH: begin
                w_ctl.run = 1'b1;
                if (r_m == w_m_hi) begin
                    n_state = dpds_pkg::S_REDUCE;
                end
            end
            dpds_pkg::S_REDUCE: begin
                if (r_cnt == CNT_REDUCE) begin
                    n_state = dpds_pkg::S_DONE;
                end
            end
            dpds_pkg::S_DONE: begin
                if (!(r_out_valid && i_out_stall)) begin
                    w_out_load = 1'b1;
                    n_state    = dpds_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dpds_pkg::S_IDLE;
            end
        endcase
        n_out_valid = (r_out_valid && i_out_stall) || w_out_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dpds_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Sweep counter, settle counter and the item's result.
    always_ff @(posedge i_clk) begin
        if (r_state == dpds_pkg::S_DIV && w_div_done) begin
            r_link   <= w_quo;
            r_status <= w_oor;
            r_m      <= w_m_lo;
        end
        if (r_state == dpds_pkg::S_SEARCH) begin
            r_m   <= r_m + dpds_pkg::W_M'(1);
            r_cnt <= '0;
        end
        if (r_state == dpds_pkg::S_REDUCE) begin
            r_cnt <= r_cnt + W_CNT'(1);
            if (r_cnt == CNT_REDUCE) begin
                r_res_m <= w_tok[dpds_pkg::NCELL].m;
                r_res_p <= w_tok[dpds_pkg::NCELL].p;
            end
        end
    end

    // Result fields; an out-of-range item carries only its link clock.
    always_comb begin
        w_seed_off = r_res_m - dpds_pkg::SEED_BASE;
        w_onehot   = dpds_pkg::W_ONEHOT'(1) << (r_res_p - dpds_pkg::W_P'(dpds_pkg::P_MIN));
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status <= r_status;
            r_out_link   <= r_link;
            r_out_m      <= r_status ? '0 : r_res_m;
            r_out_p      <= r_status ? '0 : r_res_p;
            r_out_onehot <= r_status ? '0 : w_onehot;
            r_out_nfield <= r_status ? '0 :
                            (r_platform ? dpds_pkg::NFIELD_PLAT1 : dpds_pkg::NFIELD_PLAT0);
            r_out_seed   <= r_status ? '0 :
                            dpds_pkg::SEED_TABLE[w_seed_off[dpds_pkg::W_SEEDIDX-1:0]];
        end
    end

    assign o_in_stall        = (r_state != dpds_pkg::S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_link_clock_khz  = r_out_link;
    assign o_m_divider       = r_out_m;
    assign o_p_divider       = r_out_p;
    assign o_post_div_onehot = r_out_onehot;
    assign o_n_field         = r_out_nfield;
    assign o_m_seed          = r_out_seed;

`ifndef SYNTHESIS
    // A found divider pair always comes with a link clock inside the window.
    a_found_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_status) |->
        (o_link_clock_khz >= dpds_pkg::LINK_MIN_KHZ &&
         o_link_clock_khz <= dpds_pkg::LINK_MAX_KHZ))
        else $error("found dividers for an out-of-window link clock");

    a_p_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_status) |->
        (o_p_divider >= dpds_pkg::W_P'(dpds_pkg::P_MIN) && o_p_divider <= 3'd6 &&
         $onehot(o_post_div_onehot)))
        else $error("post divider out of range or one-hot field broken");

    a_m_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_status) |->
        (o_m_divider >= dpds_pkg::M_LO_PLAT0 && o_m_divider <= dpds_pkg::M_HI_PLAT1))
        else $error("feedback divider outside every platform range");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == dpds_pkg::S_DIV))
        else $error("divider finished outside the divide phase");

    // Every accepted item is followed by the sequencer leaving idle.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == dpds_pkg::S_DIV))
        else $error("accepted item did not start the divide");
`endif

endmodule

// ===== dv/dpds_divider_checker.sv =====
// Checker of the DSI PLL divider search: watches the configuration port and both item
// channels, predicts every result and compares it field by field.
// Depends on dpds_pkg.
module dpds_divider_checker
    import dpds_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [W_CFGIDX-1:0]   i_cfg_index,
    input  logic [W_CFG-1:0]      i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [W_PCLK-1:0]     i_pixel_clock_khz,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic                  i_status,
    input  logic [W_LINK-1:0]     i_link_clock_khz,
    input  logic [W_M-1:0]        i_m_divider,
    input  logic [W_P-1:0]        i_p_divider,
    input  logic [W_ONEHOT-1:0]   i_post_div_onehot,
    input  logic [W_NFIELD-1:0]   i_n_field,
    input  logic [W_SEED-1:0]     i_m_seed,
    output int                    o_mismatch_count,
    output int                    o_pending
);

    localparam longint unsigned REF_PLAT0_KHZ = 25000;
    localparam longint unsigned N_PLAT0       = 1;
    localparam longint unsigned REF_PLAT1_KHZ = 100000;
    localparam longint unsigned N_PLAT1       = 4;
    localparam longint unsigned P_FIRST       = 2;
    localparam longint unsigned P_LAST        = 6;
    localparam longint unsigned NO_ERROR_YET  = 64'hFFFF_FFFF;

    // Seeds of the feedback divider, first entry belongs to m = 62.
    localparam logic [W_SEED-1:0] M_SEED_LUT [0:SEED_DEPTH-1] = '{
        9'd426, 9'd469, 9'd234, 9'd373, 9'd442, 9'd221, 9'd110, 9'd311, 9'd411,
        9'd461, 9'd486, 9'd243, 9'd377, 9'd188, 9'd350, 9'd175, 9'd343, 9'd427,
        9'd213, 9'd106, 9'd53,  9'd282, 9'd397, 9'd454, 9'd227, 9'd113, 9'd56,
        9'd284, 9'd142, 9'd71,  9'd35,  9'd273, 9'd136, 9'd324, 9'd418, 9'd465,
        9'd488, 9'd500, 9'd506
    };

    typedef struct packed {
        logic                status;
        logic [W_LINK-1:0]   link;
        logic [W_M-1:0]      m;
        logic [W_P-1:0]      p;
        logic [W_ONEHOT-1:0] onehot;
        logic [W_NFIELD-1:0] nfield;
        logic [W_SEED-1:0]   seed;
    } t_divider_result;

    logic              cfg_platform = 1'b0;
    logic [W_FMT-1:0]  cfg_format   = '0;
    logic [W_LANES-1:0] cfg_lanes   = LANES_RESET;
    t_divider_result   expected_dividers_q[$];

    initial begin
        o_mismatch_count = 0;
        o_pending        = 0;
    end

    // Link clock and best divider pair for one pixel clock under the current settings.
    function automatic t_divider_result predict_dividers(input logic [W_PCLK-1:0] pclk);
        t_divider_result res;
        longint unsigned lanes, bpp, link, ref_khz, n_div, m_lo, m_hi, m, p, calc, err;
        longint unsigned best_err, best_m, best_p;
        bit hit;
        res  = '0;
        hit  = 1'b0;
        lanes = (cfg_lanes == '0) ? 1 : cfg_lanes;
        if (cfg_format == FMT_RGB666_PACKED) begin
            bpp = BPP_18;
        end else if (cfg_format == FMT_RGB565) begin
            bpp = BPP_16;
        end else begin
            bpp = BPP_24;
        end
        link = (longint'(pclk) * bpp + lanes / 2) / lanes;
        res.link = link[W_LINK-1:0];
        if (link < LINK_MIN_KHZ || link > LINK_MAX_KHZ) begin
            res.status = 1'b1;
            return res;
        end
        if (cfg_platform) begin
            ref_khz = REF_PLAT1_KHZ;
            n_div   = N_PLAT1;
            m_lo    = M_LO_PLAT1;
            m_hi    = M_HI_PLAT1;
        end else begin
            ref_khz = REF_PLAT0_KHZ;
            n_div   = N_PLAT0;
            m_lo    = M_LO_PLAT0;
            m_hi    = M_HI_PLAT0;
        end
        best_err = NO_ERROR_YET;
        best_m   = m_lo;
        best_p   = P_FIRST;
        // m-major sweep; a strict less-than keeps the first minimum, and an exact
        // hit ends the sweep.
        for (m = m_lo; m <= m_hi && !hit; m++) begin
            for (p = P_FIRST; p <= P_LAST && !hit; p++) begin
                calc = (m * ref_khz) / (p * n_div);
                err  = (calc > link) ? calc - link : link - calc;
                if (err < best_err) begin
                    best_err = err;
                    best_m   = m;
                    best_p   = p;
                end
                if (err == 0) begin
                    hit = 1'b1;
                end
            end
        end
        res.m      = best_m[W_M-1:0];
        res.p      = best_p[W_P-1:0];
        res.onehot = W_ONEHOT'(1) << (best_p - P_FIRST);
        res.nfield = cfg_platform ? NFIELD_PLAT1 : NFIELD_PLAT0;
        res.seed   = M_SEED_LUT[(best_m - SEED_BASE) % SEED_DEPTH];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        o_mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_divider_result got;
        t_divider_result want;
        if (!i_rst_n) begin
            cfg_platform = 1'b0;
            cfg_format   = '0;
            cfg_lanes    = LANES_RESET;
            expected_dividers_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.status = i_status;
                got.link   = i_link_clock_khz;
                got.m      = i_m_divider;
                got.p      = i_p_divider;
                got.onehot = i_post_div_onehot;
                got.nfield = i_n_field;
                got.seed   = i_m_seed;
                if (expected_dividers_q.size() == 0) begin
                    report_mismatch("result item with no input pending", got.link, 0);
                end else begin
                    want = expected_dividers_q.pop_front();
                    if (got.status !== want.status) begin
                        report_mismatch("status", got.status, want.status);
                    end
                    if (got.link !== want.link) begin
                        report_mismatch("link_clock_khz", got.link, want.link);
                    end
                    if (got.m !== want.m) begin
                        report_mismatch("m_divider", got.m, want.m);
                    end
                    if (got.p !== want.p) begin
                        report_mismatch("p_divider", got.p, want.p);
                    end
                    if (got.onehot !== want.onehot) begin
                        report_mismatch("post_div_onehot", got.onehot, want.onehot);
                    end
                    if (got.nfield !== want.nfield) begin
                        report_mismatch("n_field", got.nfield, want.nfield);
                    end
                    if (got.seed !== want.seed) begin
                        report_mismatch("m_seed", got.seed, want.seed);
                    end
                end
            end
            // The prediction uses the settings in force before any write at this edge.
            if (i_in_valid && !i_in_stall) begin
                expected_dividers_q.push_back(predict_dividers(i_pixel_clock_khz));
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PLATFORM: begin
                        cfg_platform = i_cfg_data[0];
                    end
                    REG_PIXEL_FORMAT: begin
                        cfg_format = i_cfg_data[W_FMT-1:0];
                    end
                    REG_LANE_COUNT: begin
                        cfg_lanes = i_cfg_data[W_LANES-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending = expected_dividers_q.size();
    end

endmodule

// ===== dv/tb_dsi_pll_divider_search.sv =====
// Top level of the DSI PLL divider search testbench: clock, reset, stimulus and verdict.
// Depends on dpds_pkg, dsi_pll_divider_search and dpds_divider_checker.
module tb_dsi_pll_divider_search;
    import dpds_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int SETTLE_CYCLES   = 100;
    localparam int RUN_LIMIT       = 10_000_000;
    localparam int unsigned PCLK_MAX = (1 << W_PCLK) - 1;
    localparam int unsigned P_MAX    = P_MIN + NCELL - 1;

    // Index 3 holds no register; writes to it must leave every setting alone.
    localparam logic [W_CFGIDX-1:0] REG_SPARE = 2'd3;

    // Lane counts of the random phases, including zero and the counts above four.
    localparam logic [W_LANES-1:0] PHASE_LANES [0:NUM_PHASES-1] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd1, 3'd4, 3'd7, 3'd2
    };

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [W_CFGIDX-1:0]  cfg_index   = '0;
    logic [W_CFG-1:0]     cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic [W_PCLK-1:0]    pixel_clock = '0;
    logic                 out_stall   = 1'b0;
    logic                 in_stall;
    logic                 out_valid;
    logic                 status;
    logic [W_LINK-1:0]    link_clock;
    logic [W_M-1:0]       m_divider;
    logic [W_P-1:0]       p_divider;
    logic [W_ONEHOT-1:0]  post_div_onehot;
    logic [W_NFIELD-1:0]  n_field;
    logic [W_SEED-1:0]    m_seed;
    int                   mismatch_count;
    int                   pending;

    // Idle rates in percent of cycles for the sender and the receiver.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // Settings last written, used only to aim the pixel clocks at the search window.
    logic                 cur_platform = 1'b0;
    logic [W_FMT-1:0]     cur_format   = '0;
    logic [W_LANES-1:0]   cur_lanes    = LANES_RESET;

    always #CLK_HALF clk = ~clk;

    dsi_pll_divider_search dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_pixel_clock_khz (pixel_clock),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_status          (status),
        .o_link_clock_khz  (link_clock),
        .o_m_divider       (m_divider),
        .o_p_divider       (p_divider),
        .o_post_div_onehot (post_div_onehot),
        .o_n_field         (n_field),
        .o_m_seed          (m_seed)
    );

    dpds_divider_checker checker_i (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_pixel_clock_khz (pixel_clock),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_status          (status),
        .i_link_clock_khz  (link_clock),
        .i_m_divider       (m_divider),
        .i_p_divider       (p_divider),
        .i_post_div_onehot (post_div_onehot),
        .i_n_field         (n_field),
        .i_m_seed          (m_seed),
        .o_mismatch_count  (mismatch_count),
        .o_pending         (pending)
    );

    // The receiver draws a fresh stall decision every cycle, so stalls land on
    // every phase of the block's work.
    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Offers one item and returns once it has been accepted. The valid stays high
    // on return, so a following item goes out without a bubble unless the sender
    // decides to idle; each falling edge therefore assigns the valid only once.
    task automatic send_pixel_clock(input logic [W_PCLK-1:0] pclk);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        pixel_clock <= pclk;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    // Stops offering items and waits until every expected result has come out.
    // Every item gives a result, so an empty expectation store means the block is
    // idle; the extra wait after that is only a margin.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg_reg(input logic [W_CFGIDX-1:0] idx, input logic [W_CFG-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Unused upper data bits are filled at random; the block must ignore them.
    task automatic set_config(input logic plat, input logic [W_FMT-1:0] fmt,
                              input logic [W_LANES-1:0] lanes);
        drain_results();
        write_cfg_reg(REG_SPARE, W_CFG'($urandom_range(0, (1 << W_CFG) - 1)));
        write_cfg_reg(REG_PLATFORM, {(W_CFG-1)'($urandom_range(0, 3)), plat});
        write_cfg_reg(REG_PIXEL_FORMAT, {(W_CFG-W_FMT)'($urandom_range(0, 1)), fmt});
        write_cfg_reg(REG_LANE_COUNT, lanes);
        cur_platform = plat;
        cur_format   = fmt;
        cur_lanes    = lanes;
    endtask

    // Most pixel clocks fall inside the link window so the search runs; the rest
    // sit on the window edges, aim at exact divider hits, or span the whole field.
    function automatic logic [W_PCLK-1:0] pick_pixel_clock();
        int unsigned lanes_eff, bpp, lo, hi, sel, m, p, target, value;
        lanes_eff = (cur_lanes == '0) ? 1 : cur_lanes;
        bpp       = bits_per_pixel(cur_format);
        lo        = (LINK_MIN_KHZ * lanes_eff + bpp - 1) / bpp;
        hi        = (LINK_MAX_KHZ * lanes_eff) / bpp;
        sel       = $urandom_range(0, 99);
        if (sel < 65) begin
            value = $urandom_range(lo, hi);
        end else if (sel < 75) begin
            m      = $urandom_range(M_LO_PLAT0, M_HI_PLAT1);
            p      = $urandom_range(P_MIN, P_MAX);
            target = m * REF_PER_N / p;
            value  = (target * lanes_eff + bpp / 2) / bpp + $urandom_range(0, 1);
        end else if (sel < 85) begin
            value = ($urandom_range(0, 1) ? hi : lo) + $urandom_range(0, 4) - 2;
        end else begin
            value = $urandom_range(0, PCLK_MAX);
        end
        return value[W_PCLK-1:0];
    endfunction

    initial begin
        logic [W_PCLK-1:0] reset_cfg_pclks [0:9];
        logic [W_PCLK-1:0] packed_pclks [0:5];
        logic [W_PCLK-1:0] zero_lane_pclks [0:3];
        int phase;

        // With reset settings the link clock is six times the pixel clock: the
        // window edges, an exact hit (m 72, p 2), all zeros, all ones and two
        // alternating bit patterns.
        reset_cfg_pclks = '{20'd0, 20'hFFFFF, 20'd49999, 20'd50000, 20'd191666,
                            20'd191667, 20'd150000, 20'd123456, 20'h55555, 20'hAAAAA};
        // 18 bits per pixel over four lanes: odd pixel clocks land exactly on a
        // half and must round up; 200000 is an exact hit on the 100 MHz set.
        packed_pclks    = '{20'd66666, 20'd66667, 20'd255555, 20'd255556,
                            20'd200001, 20'd200000};
        // A lane count of zero divides by one.
        zero_lane_pclks = '{20'd18749, 20'd18750, 20'd71875, 20'd71876};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 37;
        recv_idle_pct = 88;

        foreach (reset_cfg_pclks[i]) begin
            send_pixel_clock(reset_cfg_pclks[i]);
        end
        set_config(1'b1, FMT_RGB666_PACKED, 3'd4);
        foreach (packed_pclks[i]) begin
            send_pixel_clock(packed_pclks[i]);
        end
        set_config(1'b0, FMT_RGB565, 3'd0);
        foreach (zero_lane_pclks[i]) begin
            send_pixel_clock(zero_lane_pclks[i]);
        end

        // Random phases: each one switches the settings while idle, and the idle
        // pattern flips after a third and stops after two thirds of the run.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == NUM_PHASES / 3) begin
                send_idle_pct = 88;
                recv_idle_pct = 37;
            end else if (phase == 2 * NUM_PHASES / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_config(phase[0], W_FMT'((phase / 2) % 4), PHASE_LANES[phase]);
            repeat (ITEMS_PER_PHASE) begin
                send_pixel_clock(pick_pixel_clock());
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // A hung handshake ends the run here.
    initial begin
        #RUN_LIMIT;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
